/* rtl/plrt_pkg.sv */
// plrt_pkg: shared types, constants and lookup functions for the pileup
// genotype caller. No dependencies; every rtl file refers to it by scoped name.
`default_nettype none

package plrt_pkg;

   // sizing defaults
   localparam int MAX_DEPTH_DEF   = 1023;
   localparam int QUEUE_DEPTH_DEF = 2;
   localparam int NUM_GENOTYPES   = 10;
   localparam int NUM_HOMO        = 4;
   localparam int GI_W            = $clog2(NUM_GENOTYPES);
   localparam int CNT_W           = $clog2(NUM_GENOTYPES + 1);

   // config register indexes
   localparam logic [2:0] CSR_MIN_READS     = 3'd0;
   localparam logic [2:0] CSR_CHI_THRESHOLD = 3'd1;
   localparam logic [2:0] CSR_HAPLO_ENABLE  = 3'd2;
   localparam logic [2:0] CSR_LOG_MATCH     = 3'd3;
   localparam logic [2:0] CSR_LOG_MISMATCH  = 3'd4;
   localparam logic [2:0] CSR_LOG_HET_MATCH = 3'd5;

   // config reset values
   localparam logic [9:0]         MIN_READS_RST     = 10'd6;
   localparam logic [30:0]        CHI_THRESHOLD_RST = 31'd251658;
   localparam logic               HAPLO_ENABLE_RST  = 1'b1;
   localparam logic signed [31:0] LOG_MATCH_RST     = -32'sd493;
   localparam logic signed [31:0] LOG_MISMATCH_RST  = -32'sd392656;
   localparam logic signed [31:0] LOG_HET_MATCH_RST = -32'sd91510;

   // call kinds
   localparam logic [1:0] CALL_NONE    = 2'd0;
   localparam logic [1:0] CALL_GENO    = 2'd1;
   localparam logic [1:0] CALL_HAPLO   = 2'd2;
   localparam logic [1:0] CALL_INVALID = 2'd3;

   // allele codes
   localparam logic [1:0] BASE_A   = 2'd0;
   localparam logic [1:0] BASE_C   = 2'd1;
   localparam logic [1:0] BASE_G   = 2'd2;
   localparam logic [1:0] BASE_T   = 2'd3;
   localparam logic [2:0] ALLELE_N = 3'd4;

   // lower-case ascii of the four bases
   localparam logic [7:0] CHAR_A = 8'h61;
   localparam logic [7:0] CHAR_C = 8'h63;
   localparam logic [7:0] CHAR_G = 8'h67;
   localparam logic [7:0] CHAR_T = 8'h74;
   localparam logic [7:0] CASE_BIT = 8'h20;

   // configuration as seen by the scoring side
   typedef struct packed {
      logic [9:0]         min_reads;
      logic [30:0]        chi_threshold;
      logic               haplo_enable;
      logic signed [31:0] log_match;
      logic signed [31:0] log_mismatch;
      logic signed [31:0] log_het_match;
   } cfg_type;

   // first allele of each genotype, order AA AC AG AT CC CG CT GG GT TT
   function automatic logic [1:0] geno_first(input logic [GI_W-1:0] g);
      logic [1:0] r;
      case (g)
         4'd0, 4'd1, 4'd2, 4'd3: r = BASE_A;
         4'd4, 4'd5, 4'd6:       r = BASE_C;
         4'd7, 4'd8:             r = BASE_G;
         default:                r = BASE_T;
      endcase
      return r;
   endfunction

   // second allele of each genotype
   function automatic logic [1:0] geno_second(input logic [GI_W-1:0] g);
      logic [1:0] r;
      case (g)
         4'd0:             r = BASE_A;
         4'd1, 4'd4:       r = BASE_C;
         4'd2, 4'd5, 4'd7: r = BASE_G;
         default:          r = BASE_T;
      endcase
      return r;
   endfunction

   // genotype index of each homozygous genotype
   function automatic logic [GI_W-1:0] homo_geno(input logic [1:0] b);
      logic [GI_W-1:0] r;
      case (b)
         BASE_A:  r = GI_W'(0);
         BASE_C:  r = GI_W'(4);
         BASE_G:  r = GI_W'(7);
         default: r = GI_W'(9);
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

/* rtl/plrt_front.sv */
// plrt_front: takes base items, classifies them and keeps the saturating counts.
// Pushes a pileup snapshot on the closing item. Uses plrt_pkg.
`default_nettype none

module plrt_front #(
   parameter int MAX_DEPTH = plrt_pkg::MAX_DEPTH_DEF,
   parameter int CW        = $clog2(MAX_DEPTH + 1),
   parameter int SNAP_W    = 5 * CW + 1
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              accept,
   input  wire logic [7:0]        base_char,
   input  wire logic              no_base,
   input  wire logic              last_of_pileup,
   output logic                   push,
   output logic [SNAP_W-1:0]      snap
);

   typedef struct packed {
      logic          bad;
      logic [CW-1:0] total;
      logic [CW-1:0] n3;
      logic [CW-1:0] n2;
      logic [CW-1:0] n1;
      logic [CW-1:0] n0;
   } snap_type;

   localparam logic [CW-1:0] SAT = CW'(MAX_DEPTH);

   snap_type cur_ff, cur_in, upd;
   logic [7:0] lc;
   logic       is_base;
   logic [1:0] base_idx;

   // case-folded base decode
   always_comb begin
      lc       = base_char | plrt_pkg::CASE_BIT;
      is_base  = 1'b1;
      base_idx = plrt_pkg::BASE_A;
      case (lc)
         plrt_pkg::CHAR_A: base_idx = plrt_pkg::BASE_A;
         plrt_pkg::CHAR_C: base_idx = plrt_pkg::BASE_C;
         plrt_pkg::CHAR_G: base_idx = plrt_pkg::BASE_G;
         plrt_pkg::CHAR_T: base_idx = plrt_pkg::BASE_T;
         default:          is_base  = 1'b0;
      endcase
   end

   // count update, cleared once the pileup is closed
   always_comb begin
      upd = cur_ff;
      if (!no_base) begin
         if (!is_base) begin
            upd.bad = 1'b1;
         end else begin
            if (cur_ff.total < SAT) upd.total = cur_ff.total + CW'(1);
            case (base_idx)
               plrt_pkg::BASE_A: if (cur_ff.n0 < SAT) upd.n0 = cur_ff.n0 + CW'(1);
               plrt_pkg::BASE_C: if (cur_ff.n1 < SAT) upd.n1 = cur_ff.n1 + CW'(1);
               plrt_pkg::BASE_G: if (cur_ff.n2 < SAT) upd.n2 = cur_ff.n2 + CW'(1);
               default:          if (cur_ff.n3 < SAT) upd.n3 = cur_ff.n3 + CW'(1);
            endcase
         end
      end
      cur_in = cur_ff;
      if (accept) cur_in = last_of_pileup ? '0 : upd;
   end

   assign push = accept && last_of_pileup;
   assign snap = SNAP_W'(upd);

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff <= '0;
      end else begin
         cur_ff <= cur_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/plrt_queue.sv */
// plrt_queue: short snapshot queue between the counting and the scoring side.
// Standalone, uses plrt_pkg for its default depth.
`default_nettype none

module plrt_queue #(
   parameter int DEPTH  = plrt_pkg::QUEUE_DEPTH_DEF,
   parameter int DATA_W = 8
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire logic [DATA_W-1:0] push_data,
   input  wire logic              pop,
   output logic [DATA_W-1:0]      head,
   output logic                   full,
   output logic                   empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int FW = $clog2(DEPTH + 1);

   logic [DATA_W-1:0] entry_ff [DEPTH];
   logic [PW-1:0]     wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [FW-1:0]     fill_ff, fill_in;

   assign full  = (fill_ff == FW'(DEPTH));
   assign empty = (fill_ff == FW'(0));
   assign head  = entry_ff[rd_ptr_ff];

   // pointer wrap and fill tracking
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? PW'(0) : wr_ptr_ff + PW'(1);
      if (pop)  rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? PW'(0) : rd_ptr_ff + PW'(1);
      if (push && !pop)      fill_in = fill_ff + FW'(1);
      else if (pop && !push) fill_in = fill_ff - FW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= push_data;
   end

endmodule

`default_nettype wire

/* rtl/plrt_back.sv */
// plrt_back: scoring sequencer. Scores ten genotypes with one shared multiplier,
// finds best and runner-up, applies the ratio test, emits the result. Uses plrt_pkg.
`default_nettype none

module plrt_back #(
   parameter int MAX_DEPTH = plrt_pkg::MAX_DEPTH_DEF,
   parameter int CW        = $clog2(MAX_DEPTH + 1),
   parameter int SNAP_W    = 5 * CW + 1
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire plrt_pkg::cfg_type cfg,
   input  wire logic [SNAP_W-1:0] head,
   input  wire logic              empty,
   output logic                   pop,
   output logic                   rsp_valid,
   output logic [1:0]             rsp_call_kind,
   output logic [2:0]             rsp_first_allele,
   output logic [2:0]             rsp_second_allele,
   output logic [9:0]             rsp_read_count
);

   typedef struct packed {
      logic          bad;
      logic [CW-1:0] total;
      logic [CW-1:0] n3;
      logic [CW-1:0] n2;
      logic [CW-1:0] n1;
      logic [CW-1:0] n0;
   } snap_type;

   localparam int AW = CW + 2;        // sum of up to four counts
   localparam int SW = AW + 35;       // score width
   localparam int NG = plrt_pkg::NUM_GENOTYPES;
   localparam int GW = plrt_pkg::GI_W;
   localparam int KW = plrt_pkg::CNT_W;
   localparam int TW = CW + 10;       // compare width against 10-bit fields

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_LOAD  = 3'd1;
   localparam logic [2:0] ST_SCORE = 3'd2;
   localparam logic [2:0] ST_PICK  = 3'd3;
   localparam logic [2:0] ST_EVAL  = 3'd4;

   localparam logic signed [SW-1:0] SCORE_MIN = {1'b1, {(SW-1){1'b0}}};

   snap_type              snap_ff, snap_in, hd;
   logic [AW-1:0]         t_ff, t_in;
   logic [2:0]            state_ff, state_in;
   logic [KW-1:0]         cnt_ff, cnt_in;
   logic                  hmode_ff, hmode_in;
   logic signed [SW-1:0]  tm_ff, tm_in;
   logic signed [32:0]    dhom_ff, dhom_in, dhet_ff, dhet_in;
   logic signed [SW-1:0]  prod_ff, prod_in;
   logic signed [SW-1:0]  sc_ff [NG];
   logic                  sc_we;
   logic [GW-1:0]         sc_widx;
   logic signed [SW-1:0]  best_ff, best_in, second_ff, second_in;
   logic [GW-1:0]         bidx_ff, bidx_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [1:0]            kind_ff, kind_in;
   logic [2:0]            a1_ff, a1_in, a2_ff, a2_in;
   logic [9:0]            rc_ff, rc_in;

   logic [GW-1:0]         g;
   logic [1:0]            fa, sa;
   logic [AW-1:0]         nf, ns, a_sel;
   logic signed [32:0]    d_sel;
   logic signed [AW+33:0] mult;
   logic signed [AW+32:0] tmult;
   logic [GW-1:0]         ridx;
   logic signed [SW-1:0]  s;
   logic [SW-1:0]         gap;
   logic                  sig, geno_try, haplo_try, last_pick;
   logic [TW-1:0]         tot_ext;

   function automatic logic [AW-1:0] count_of(input logic [1:0] b, input snap_type p);
      logic [AW-1:0] r;
      case (b)
         plrt_pkg::BASE_A: r = AW'(p.n0);
         plrt_pkg::BASE_C: r = AW'(p.n1);
         plrt_pkg::BASE_G: r = AW'(p.n2);
         default:          r = AW'(p.n3);
      endcase
      return r;
   endfunction

   assign hd = snap_type'(head);

   // decision inputs from the held snapshot
   always_comb begin
      tot_ext   = TW'(snap_ff.total);
      geno_try  = tot_ext >= TW'(cfg.min_reads);
      haplo_try = cfg.haplo_enable && (geno_try || tot_ext > TW'(1));
   end

   // genotype operand select and the shared multiplier
   always_comb begin
      g     = cnt_ff[GW-1:0];
      fa    = plrt_pkg::geno_first(g);
      sa    = plrt_pkg::geno_second(g);
      nf    = count_of(fa, snap_ff);
      ns    = count_of(sa, snap_ff);
      a_sel = (fa == sa) ? nf : nf + ns;
      d_sel = (fa == sa) ? dhom_ff : dhet_ff;
      mult  = $signed({1'b0, a_sel}) * d_sel;
      tmult = $signed({1'b0, t_ff}) * cfg.log_mismatch;
   end

   // score read for the top-two search
   always_comb begin
      ridx = hmode_ff ? plrt_pkg::homo_geno(cnt_ff[1:0]) : cnt_ff[GW-1:0];
      s    = sc_ff[ridx];
      gap  = best_ff - second_ff;
      sig  = {gap, 1'b0} >= (SW+1)'(cfg.chi_threshold);
      last_pick = hmode_ff ? (cnt_ff == KW'(plrt_pkg::NUM_HOMO - 1))
                           : (cnt_ff == KW'(NG - 1));
   end

   // sequencer
   always_comb begin
      snap_in      = snap_ff;
      t_in         = t_ff;
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      hmode_in     = hmode_ff;
      tm_in        = tm_ff;
      dhom_in      = dhom_ff;
      dhet_in      = dhet_ff;
      prod_in      = prod_ff;
      best_in      = best_ff;
      second_in    = second_ff;
      bidx_in      = bidx_ff;
      rsp_valid_in = 1'b0;
      kind_in      = kind_ff;
      a1_in        = a1_ff;
      a2_in        = a2_ff;
      rc_in        = rc_ff;
      pop          = 1'b0;
      sc_we        = 1'b0;
      sc_widx      = GW'(cnt_ff - KW'(1));

      case (state_ff)
         ST_IDLE: begin
            if (!empty) begin
               pop      = 1'b1;
               snap_in  = hd;
               t_in     = AW'(hd.n0) + AW'(hd.n1) + AW'(hd.n2) + AW'(hd.n3);
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            tm_in   = SW'(tmult);
            dhom_in = 33'(cfg.log_match) - 33'(cfg.log_mismatch);
            dhet_in = 33'(cfg.log_het_match) - 33'(cfg.log_mismatch);
            cnt_in  = '0;
            rc_in   = (tot_ext > TW'(1023)) ? 10'd1023 : tot_ext[9:0];
            if (snap_ff.bad) begin
               rsp_valid_in = 1'b1;
               kind_in      = plrt_pkg::CALL_INVALID;
               a1_in        = plrt_pkg::ALLELE_N;
               a2_in        = plrt_pkg::ALLELE_N;
               state_in     = ST_IDLE;
            end else begin
               state_in = ST_SCORE;
            end
         end
         ST_SCORE: begin
            // product for genotype cnt, sum for genotype cnt-1
            if (cnt_ff != KW'(NG)) prod_in = SW'(mult);
            if (cnt_ff != KW'(0)) sc_we = 1'b1;
            cnt_in = cnt_ff + KW'(1);
            if (cnt_ff == KW'(NG)) begin
               cnt_in = '0;
               if (geno_try) begin
                  hmode_in = 1'b0;
                  state_in = ST_PICK;
               end else if (haplo_try) begin
                  hmode_in = 1'b1;
                  state_in = ST_PICK;
               end else begin
                  rsp_valid_in = 1'b1;
                  kind_in      = plrt_pkg::CALL_NONE;
                  a1_in        = plrt_pkg::ALLELE_N;
                  a2_in        = plrt_pkg::ALLELE_N;
                  state_in     = ST_IDLE;
               end
            end
         end
         ST_PICK: begin
            // running best and second-best, ties go to the earlier entry
            if (cnt_ff == KW'(0)) begin
               best_in   = s;
               second_in = SCORE_MIN;
               bidx_in   = '0;
            end else if (s > best_ff) begin
               second_in = best_ff;
               best_in   = s;
               bidx_in   = cnt_ff[GW-1:0];
            end else if (s > second_ff) begin
               second_in = s;
            end
            cnt_in = cnt_ff + KW'(1);
            if (last_pick) state_in = ST_EVAL;
         end
         ST_EVAL: begin
            cnt_in   = '0;
            state_in = ST_IDLE;
            if (sig) begin
               rsp_valid_in = 1'b1;
               if (hmode_ff) begin
                  kind_in = plrt_pkg::CALL_HAPLO;
                  a1_in   = {1'b0, bidx_ff[1:0]};
                  a2_in   = plrt_pkg::ALLELE_N;
               end else begin
                  kind_in = plrt_pkg::CALL_GENO;
                  a1_in   = {1'b0, plrt_pkg::geno_first(bidx_ff)};
                  a2_in   = {1'b0, plrt_pkg::geno_second(bidx_ff)};
               end
            end else if (!hmode_ff && haplo_try) begin
               hmode_in = 1'b1;
               state_in = ST_PICK;
            end else begin
               rsp_valid_in = 1'b1;
               kind_in      = plrt_pkg::CALL_NONE;
               a1_in        = plrt_pkg::ALLELE_N;
               a2_in        = plrt_pkg::ALLELE_N;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         hmode_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         hmode_ff     <= hmode_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      snap_ff   <= snap_in;
      t_ff      <= t_in;
      tm_ff     <= tm_in;
      dhom_ff   <= dhom_in;
      dhet_ff   <= dhet_in;
      prod_ff   <= prod_in;
      best_ff   <= best_in;
      second_ff <= second_in;
      bidx_ff   <= bidx_in;
      kind_ff   <= kind_in;
      a1_ff     <= a1_in;
      a2_ff     <= a2_in;
      rc_ff     <= rc_in;
      if (sc_we) sc_ff[sc_widx] <= prod_ff + tm_ff;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_call_kind     = kind_ff;
   assign rsp_first_allele  = a1_ff;
   assign rsp_second_allele = a2_ff;
   assign rsp_read_count    = rc_ff;

endmodule

`default_nettype wire

/* rtl/pileup_genotype_lrt_caller.sv */
// Top level of the pileup genotype caller: config registers, counting front,
// snapshot queue and scoring back. Uses plrt_pkg, plrt_front, plrt_queue, plrt_back.
//
// Base items are taken one per clock whenever busy is low (start high and busy
// low accepts an item); the closing item of a pileup also hands a count
// snapshot to a queue. The scoring sequencer scores one genotype per cycle and
// searches one score per cycle. A popped snapshot is loaded, all ten genotypes
// are scored, then a diploid search and evaluation, a haploid one alone, the
// haploid one after a failed diploid one, or no test at all. An invalid base
// gives its result straight from the load step. The sequencer takes the
// next snapshot in the cycle its result is shown. The queue holds QUEUE_DEPTH
// closed pileups; busy rises only while it is full. Each result is shown for
// one cycle with rsp_valid and cannot be held off.
`default_nettype none

module pileup_genotype_lrt_caller #(
   parameter int MAX_DEPTH   = plrt_pkg::MAX_DEPTH_DEF,
   parameter int QUEUE_DEPTH = plrt_pkg::QUEUE_DEPTH_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [7:0]  req_base_char,
   input  wire logic        req_no_base,
   input  wire logic        req_last_of_pileup,
   output logic             rsp_valid,
   output logic [1:0]       rsp_call_kind,
   output logic [2:0]       rsp_first_allele,
   output logic [2:0]       rsp_second_allele,
   output logic [9:0]       rsp_read_count,
   input  wire logic        csr_wr_en,
   input  wire logic [2:0]  csr_index,
   input  wire logic [31:0] csr_wr_data
);

   localparam int CW     = $clog2(MAX_DEPTH + 1);
   localparam int SNAP_W = 5 * CW + 1;

   plrt_pkg::cfg_type cfg_ff, cfg_in;
   logic              accept, push, pop, full, empty;
   logic [SNAP_W-1:0] snap, head;

   // config register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            plrt_pkg::CSR_MIN_READS:     cfg_in.min_reads     = csr_wr_data[9:0];
            plrt_pkg::CSR_CHI_THRESHOLD: cfg_in.chi_threshold = csr_wr_data[30:0];
            plrt_pkg::CSR_HAPLO_ENABLE:  cfg_in.haplo_enable  = csr_wr_data[0];
            plrt_pkg::CSR_LOG_MATCH:     cfg_in.log_match     = $signed(csr_wr_data);
            plrt_pkg::CSR_LOG_MISMATCH:  cfg_in.log_mismatch  = $signed(csr_wr_data);
            plrt_pkg::CSR_LOG_HET_MATCH: cfg_in.log_het_match = $signed(csr_wr_data);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_reads     <= plrt_pkg::MIN_READS_RST;
         cfg_ff.chi_threshold <= plrt_pkg::CHI_THRESHOLD_RST;
         cfg_ff.haplo_enable  <= plrt_pkg::HAPLO_ENABLE_RST;
         cfg_ff.log_match     <= plrt_pkg::LOG_MATCH_RST;
         cfg_ff.log_mismatch  <= plrt_pkg::LOG_MISMATCH_RST;
         cfg_ff.log_het_match <= plrt_pkg::LOG_HET_MATCH_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // item handshake
   assign busy   = full;
   assign accept = start && !full;

   plrt_front #(
      .MAX_DEPTH (MAX_DEPTH),
      .CW        (CW),
      .SNAP_W    (SNAP_W)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .base_char      (req_base_char),
      .no_base        (req_no_base),
      .last_of_pileup (req_last_of_pileup),
      .push           (push),
      .snap           (snap)
   );

   plrt_queue #(
      .DEPTH  (QUEUE_DEPTH),
      .DATA_W (SNAP_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (snap),
      .pop       (pop),
      .head      (head),
      .full      (full),
      .empty     (empty)
   );

   plrt_back #(
      .MAX_DEPTH (MAX_DEPTH),
      .CW        (CW),
      .SNAP_W    (SNAP_W)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg_ff),
      .head              (head),
      .empty             (empty),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_call_kind     (rsp_call_kind),
      .rsp_first_allele  (rsp_first_allele),
      .rsp_second_allele (rsp_second_allele),
      .rsp_read_count    (rsp_read_count)
   );

endmodule

`default_nettype wire

/* verif/testbench.sv */
`timescale 1ns / 100ps
// testbench: self-checking bench for pileup_genotype_lrt_caller, with a driver,
// a monitor and an inline genotype-call predictor. Depends on plrt_pkg and the rtl.

module testbench;

   localparam int SETTLE_CYCLES = 40;

   // genotype order AA AC AG AT CC CG CT GG GT TT
   localparam logic [1:0] GENO_HI [plrt_pkg::NUM_GENOTYPES] =
      '{plrt_pkg::BASE_A, plrt_pkg::BASE_A, plrt_pkg::BASE_A, plrt_pkg::BASE_A,
        plrt_pkg::BASE_C, plrt_pkg::BASE_C, plrt_pkg::BASE_C, plrt_pkg::BASE_G,
        plrt_pkg::BASE_G, plrt_pkg::BASE_T};
   localparam logic [1:0] GENO_LO [plrt_pkg::NUM_GENOTYPES] =
      '{plrt_pkg::BASE_A, plrt_pkg::BASE_C, plrt_pkg::BASE_G, plrt_pkg::BASE_T,
        plrt_pkg::BASE_C, plrt_pkg::BASE_G, plrt_pkg::BASE_T, plrt_pkg::BASE_G,
        plrt_pkg::BASE_T, plrt_pkg::BASE_T};
   localparam int HOMO_SLOT [plrt_pkg::NUM_HOMO] = '{0, 4, 7, 9};

   typedef struct packed {
      logic [7:0] ch;
      logic       no_base;
      logic       closes;
   } read_item_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [2:0] allele_hi;
      logic [2:0] allele_lo;
      logic [9:0] reads;
   } call_type;

   // dut ports
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [7:0]  req_base_char = 8'h00;
   logic        req_no_base = 1'b0;
   logic        req_last_of_pileup = 1'b0;
   logic        rsp_valid;
   logic [1:0]  rsp_call_kind;
   logic [2:0]  rsp_first_allele;
   logic [2:0]  rsp_second_allele;
   logic [9:0]  rsp_read_count;
   logic        csr_wr_en = 1'b0;
   logic [2:0]  csr_index = plrt_pkg::CSR_MIN_READS;
   logic [31:0] csr_wr_data = 32'h0;

   // stimulus and scoreboard state
   read_item_type pileup_feed [$];
   call_type      expected_calls [$];
   read_item_type next_item;
   int            queued_count = 0;
   int            taken_count = 0;
   int            pileups_closed = 0;
   int            settings_count = 1;
   int            mismatches = 0;
   int            seen_kind [4] = '{0, 0, 0, 0};
   int            hold_off = 0;
   bit            no_gaps = 1'b0;
   bit            item_taken = 1'b0;

   // shadow of the configuration registers
   logic [9:0]  cfg_min_reads = plrt_pkg::MIN_READS_RST;
   logic [30:0] cfg_chi = plrt_pkg::CHI_THRESHOLD_RST;
   bit          cfg_haplo = plrt_pkg::HAPLO_ENABLE_RST;
   longint      cfg_log_match = plrt_pkg::LOG_MATCH_RST;
   longint      cfg_log_mismatch = plrt_pkg::LOG_MISMATCH_RST;
   longint      cfg_log_het = plrt_pkg::LOG_HET_MATCH_RST;

   // running pileup tallies
   logic [9:0] pile_count [4] = '{10'd0, 10'd0, 10'd0, 10'd0};
   logic [9:0] pile_total = 10'd0;
   bit         pile_bad = 1'b0;

   pileup_genotype_lrt_caller u_dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_base_char      (req_base_char),
      .req_no_base        (req_no_base),
      .req_last_of_pileup (req_last_of_pileup),
      .rsp_valid          (rsp_valid),
      .rsp_call_kind      (rsp_call_kind),
      .rsp_first_allele   (rsp_first_allele),
      .rsp_second_allele  (rsp_second_allele),
      .rsp_read_count     (rsp_read_count),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wr_data        (csr_wr_data)
   );

   always #5 clock = ~clock;

   // case-blind base decode, returns 0 for anything but a c g t
   function automatic bit decode_base(input logic [7:0] ch, output logic [1:0] b);
      b = plrt_pkg::BASE_A;
      case (ch | plrt_pkg::CASE_BIT)
         plrt_pkg::CHAR_A: b = plrt_pkg::BASE_A;
         plrt_pkg::CHAR_C: b = plrt_pkg::BASE_C;
         plrt_pkg::CHAR_G: b = plrt_pkg::BASE_G;
         plrt_pkg::CHAR_T: b = plrt_pkg::BASE_T;
         default:          return 1'b0;
      endcase
      return 1'b1;
   endfunction

   function automatic logic [7:0] char_of_base(input logic [1:0] b);
      case (b)
         plrt_pkg::BASE_A: return plrt_pkg::CHAR_A;
         plrt_pkg::BASE_C: return plrt_pkg::CHAR_C;
         plrt_pkg::BASE_G: return plrt_pkg::CHAR_G;
         default:          return plrt_pkg::CHAR_T;
      endcase
   endfunction

   // best score (first of the highest) and runner-up search, then the ratio test
   function automatic void lrt_select(input longint sc [plrt_pkg::NUM_GENOTYPES],
                                      input int n, output int best, output bit signif);
      int mx;
      int sm;
      longint unsigned gap;
      mx = 0;
      for (int i = 0; i < n; i++)
         if (sc[i] > sc[mx]) mx = i;
      sm = (mx + 1) % n;
      for (int i = 0; i < n; i++)
         if (sc[i] > sc[sm] && i != mx) sm = i;
      gap = sc[mx] - sc[sm];
      best = mx;
      signif = (gap * 2) >= {33'd0, cfg_chi};
   endfunction

   // count one item; on the closing item score the pileup and queue the call
   task automatic tally_item(input logic [7:0] ch, input logic no_base, input logic closes);
      logic [1:0] b;
      longint     sc [plrt_pkg::NUM_GENOTYPES];
      longint     hs [plrt_pkg::NUM_GENOTYPES];
      longint     t;
      longint     nx;
      longint     both;
      int         best;
      bit         signif;
      bit         geno_try;
      bit         haplo_try;
      call_type   c;
      if (!no_base) begin
         if (decode_base(ch, b)) begin
            if (pile_count[b] < plrt_pkg::MAX_DEPTH_DEF) pile_count[b]++;
            if (pile_total < plrt_pkg::MAX_DEPTH_DEF) pile_total++;
         end else begin
            pile_bad = 1'b1;
         end
      end
      if (!closes) return;

      c.kind = plrt_pkg::CALL_NONE;
      c.allele_hi = plrt_pkg::ALLELE_N;
      c.allele_lo = plrt_pkg::ALLELE_N;
      c.reads = pile_total;
      if (pile_bad) begin
         c.kind = plrt_pkg::CALL_INVALID;
      end else begin
         // linear scores from the counts, total taken as the unsaturated sum
         t = 0;
         for (int i = 0; i < 4; i++) t += pile_count[i];
         for (int g = 0; g < plrt_pkg::NUM_GENOTYPES; g++) begin
            nx = pile_count[GENO_HI[g]];
            if (GENO_HI[g] == GENO_LO[g]) begin
               sc[g] = nx * cfg_log_match + (t - nx) * cfg_log_mismatch;
            end else begin
               both = nx + pile_count[GENO_LO[g]];
               sc[g] = both * cfg_log_het + (t - both) * cfg_log_mismatch;
            end
         end
         for (int i = 0; i < plrt_pkg::NUM_GENOTYPES; i++)
            hs[i] = (i < plrt_pkg::NUM_HOMO) ? sc[HOMO_SLOT[i]] : 0;
         geno_try = pile_total >= cfg_min_reads;
         haplo_try = cfg_haplo && (geno_try || pile_total > 1);
         lrt_select(sc, plrt_pkg::NUM_GENOTYPES, best, signif);
         if (geno_try && signif) begin
            c.kind = plrt_pkg::CALL_GENO;
            c.allele_hi = {1'b0, GENO_HI[best]};
            c.allele_lo = {1'b0, GENO_LO[best]};
         end else begin
            lrt_select(hs, plrt_pkg::NUM_HOMO, best, signif);
            if (haplo_try && signif) begin
               c.kind = plrt_pkg::CALL_HAPLO;
               c.allele_hi = 3'(best);
            end
         end
      end
      expected_calls.push_back(c);
      pileups_closed++;
      for (int i = 0; i < 4; i++) pile_count[i] = 10'd0;
      pile_total = 10'd0;
      pile_bad = 1'b0;
   endtask

   task automatic report_mismatch(input string what, input longint got, input longint want);
      mismatches++;
      $display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
   endtask

   // driver: present the next item at the falling edge once the previous one is taken
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!start || item_taken) begin
         if (hold_off > 0) begin
            start <= 1'b0;
            hold_off = hold_off - 1;
         end else if (pileup_feed.size() != 0) begin
            next_item = pileup_feed.pop_front();
            start <= 1'b1;
            req_base_char <= next_item.ch;
            req_no_base <= next_item.no_base;
            req_last_of_pileup <= next_item.closes;
            if ($urandom_range(0, 39) == 0) no_gaps = !no_gaps;
            hold_off = no_gaps ? 0 : $urandom_range(0, 4);
         end else begin
            start <= 1'b0;
         end
      end
   end

   // driver: note acceptance and predict from the item the block took
   always @(posedge clock) begin
      item_taken = !reset && start && !busy;
      if (item_taken) begin
         taken_count++;
         tally_item(req_base_char, req_no_base, req_last_of_pileup);
      end
   end

   // monitor: every result against the oldest expected call
   always @(posedge clock) begin
      call_type want;
      if (!reset && rsp_valid) begin
         seen_kind[rsp_call_kind]++;
         if (expected_calls.size() == 0) begin
            report_mismatch("result with no pileup closed", rsp_call_kind, -1);
         end else begin
            want = expected_calls.pop_front();
            if (rsp_call_kind !== want.kind)
               report_mismatch("call_kind", rsp_call_kind, want.kind);
            if (rsp_first_allele !== want.allele_hi)
               report_mismatch("first_allele", rsp_first_allele, want.allele_hi);
            if (rsp_second_allele !== want.allele_lo)
               report_mismatch("second_allele", rsp_second_allele, want.allele_lo);
            if (rsp_read_count !== want.reads)
               report_mismatch("read_count", rsp_read_count, want.reads);
         end
      end
   end

   task automatic queue_base(input logic [7:0] ch, input logic no_base, input logic closes);
      read_item_type it;
      it.ch = ch;
      it.no_base = no_base;
      it.closes = closes;
      pileup_feed.push_back(it);
      queued_count++;
   endtask

   // one pileup from a string of base letters, closed on the final one
   task automatic queue_bases(input string s);
      for (int i = 0; i < s.len(); i++)
         queue_base(s[i], 1'b0, i == s.len() - 1);
   endtask

   // pileup dominated by one or two bases, with gaps and the odd bad base, or an empty one
   task automatic queue_random_pileup();
      int         len;
      int         r;
      bit         with_bad;
      logic       no_base;
      logic [1:0] major;
      logic [1:0] minor;
      logic [1:0] b;
      logic [7:0] ch;
      if ($urandom_range(0, 19) == 0) begin
         queue_base(8'($urandom), 1'b1, 1'b1);
         return;
      end
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      with_bad = $urandom_range(0, 7) == 0;
      major = 2'($urandom);
      minor = 2'($urandom);
      for (int i = 0; i < len; i++) begin
         r = $urandom_range(0, 99);
         no_base = 1'b0;
         if (r < 8) begin
            no_base = 1'b1;
            ch = 8'($urandom);
         end else if (with_bad && r < 16) begin
            do ch = 8'($urandom); while (decode_base(ch, b));
         end else begin
            b = (r < 70) ? major : (r < 90) ? minor : 2'($urandom);
            ch = char_of_base(b) ^ ($urandom_range(0, 1) ? plrt_pkg::CASE_BIT : 8'h00);
         end
         queue_base(ch, no_base, i == len - 1);
      end
   endtask

   task automatic queue_random_items(input int n_items);
      int target;
      target = queued_count + n_items;
      while (queued_count < target) queue_random_pileup();
   endtask

   // wait for every queued item and call, then let the block settle
   task automatic wait_drained();
      while (taken_count != queued_count || expected_calls.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wr_data <= data;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         plrt_pkg::CSR_MIN_READS:     cfg_min_reads = data[9:0];
         plrt_pkg::CSR_CHI_THRESHOLD: cfg_chi = data[30:0];
         plrt_pkg::CSR_HAPLO_ENABLE:  cfg_haplo = data[0];
         plrt_pkg::CSR_LOG_MATCH:     cfg_log_match = longint'($signed(data));
         plrt_pkg::CSR_LOG_MISMATCH:  cfg_log_mismatch = longint'($signed(data));
         plrt_pkg::CSR_LOG_HET_MATCH: cfg_log_het = longint'($signed(data));
         default: ;
      endcase
   endtask

   task automatic write_settings(input logic [9:0] min_reads, input logic [30:0] chi,
                                 input logic haplo, input logic [31:0] lm,
                                 input logic [31:0] lmm, input logic [31:0] lhet);
      write_reg(plrt_pkg::CSR_MIN_READS, 32'(min_reads));
      write_reg(plrt_pkg::CSR_CHI_THRESHOLD, 32'(chi));
      write_reg(plrt_pkg::CSR_HAPLO_ENABLE, 32'(haplo));
      write_reg(plrt_pkg::CSR_LOG_MATCH, lm);
      write_reg(plrt_pkg::CSR_LOG_MISMATCH, lmm);
      write_reg(plrt_pkg::CSR_LOG_HET_MATCH, lhet);
      settings_count++;
   endtask

   // log value anywhere from the most negative up to zero
   function automatic logic [31:0] rand_log();
      return 32'(-longint'($urandom_range(0, 32'h8000_0000)));
   endfunction

   // stimulus sequence
   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed pileups under reset settings
      queue_base(8'h00, 1'b1, 1'b1);      // empty pileup
      queue_bases("AaAaAA");              // homozygous, mixed case
      queue_bases("CgCgcG");              // heterozygous
      queue_bases("Tt");                  // too few reads, haploid fallback
      queue_bases("g");                   // single read, no attempt
      queue_base("A", 1'b0, 1'b0);        // bad base inside, gap item ignored
      queue_base(8'hFF, 1'b0, 1'b0);
      queue_base("N", 1'b1, 1'b0);
      queue_base("c", 1'b0, 1'b1);
      queue_bases("TTT");                 // closed on its final base; the next item is an empty pileup
      queue_base(8'h78, 1'b1, 1'b1);
      wait_drained();

      queue_random_items(130);
      wait_drained();

      // deep pileup: one base and the total both saturate
      for (int i = 0; i < 1030; i++)
         queue_base(plrt_pkg::CHAR_A ^ ($urandom_range(0, 1) ? plrt_pkg::CASE_BIT : 8'h00),
                    1'b0, 1'b0);
      queue_bases("CcCcC");
      wait_drained();

      // zero threshold, no read floor, haploid off
      write_settings(10'd0, 31'd0, 1'b0, plrt_pkg::LOG_MATCH_RST,
                     plrt_pkg::LOG_MISMATCH_RST, plrt_pkg::LOG_HET_MATCH_RST);
      queue_random_items(110);
      wait_drained();

      // read floor out of reach, top threshold, extreme logs
      write_settings(10'd1023, 31'h7FFF_FFFF, 1'b1, 32'h0, 32'h8000_0000, 32'h8000_0000);
      queue_random_items(110);
      wait_drained();

      write_settings(10'd1, 31'($urandom_range(0, 1 << 24)), 1'b1,
                     rand_log(), rand_log(), rand_log());
      queue_random_items(110);
      wait_drained();

      write_settings(10'($urandom_range(2, 10)), 31'($urandom_range(0, 1 << 22)),
                     1'($urandom_range(0, 1)),
                     32'(plrt_pkg::LOG_MATCH_RST - $urandom_range(0, 2000)),
                     32'(plrt_pkg::LOG_MISMATCH_RST + $urandom_range(0, 50000)),
                     32'(plrt_pkg::LOG_HET_MATCH_RST - $urandom_range(0, 20000)));
      queue_random_items(110);
      wait_drained();

      // all scores tie, so the first genotype wins at zero threshold
      write_settings(10'd3, 31'd0, 1'b1, 32'h0, 32'h0, 32'h0);
      queue_random_items(110);
      wait_drained();

      write_settings(plrt_pkg::MIN_READS_RST, plrt_pkg::CHI_THRESHOLD_RST,
                     plrt_pkg::HAPLO_ENABLE_RST, plrt_pkg::LOG_MATCH_RST,
                     plrt_pkg::LOG_MISMATCH_RST, plrt_pkg::LOG_HET_MATCH_RST);
      queue_random_items(110);
      wait_drained();

      $display("covered %0d items in %0d pileups under %0d register settings",
               taken_count, pileups_closed, settings_count);
      $display("calls seen: %0d genotype, %0d haplotype, %0d none, %0d invalid base",
               seen_kind[plrt_pkg::CALL_GENO], seen_kind[plrt_pkg::CALL_HAPLO],
               seen_kind[plrt_pkg::CALL_NONE], seen_kind[plrt_pkg::CALL_INVALID]);
      if (mismatches == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // watchdog
   initial begin
      #5_000_000;
      $display("run timed out with %0d calls outstanding", expected_calls.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

/* files.f */
rtl/plrt_pkg.sv
rtl/plrt_front.sv
rtl/plrt_queue.sv
rtl/plrt_back.sv
rtl/pileup_genotype_lrt_caller.sv
verif/testbench.sv
